[rtl/fixed_block_free_list_allocator_defines.svh]
// Assertion macros for the fixed block free list allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FBFL_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define FBFL_ASSERT_ALWAYS(label, clk, rst_n, a, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a)) else $error(msg);
`else
`define FBFL_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define FBFL_ASSERT_ALWAYS(label, clk, rst_n, a, msg)
`endif
`endif

[rtl/fbfl_pkg.sv]
// Types and constants shared by the free list allocator modules.
package fbfl_pkg;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;
  localparam logic [1:0] REQ_STATS = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_MISALIGNED = 3'd3;
  localparam logic [2:0] ST_BAD_CONFIG = 3'd4;

  localparam logic [1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [1:0] REG_REGION_BYTES = 2'd1;
  localparam logic [1:0] REG_ITEM_BYTES   = 2'd2;

  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] release_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] block_addr;
    logic [47:0] bytes_in_use;
    logic [47:0] bytes_total;
    logic [31:0] live_allocations;
    logic [31:0] free_tally;
  } out_item_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_DIV_CNT,
    S_MUL_SPAN,
    S_LINK,
    S_STATS
  } fsm_state_t;

endpackage

[rtl/fixed_block_free_list_allocator.sv]
// Top level of the fixed block free list allocator.
// One request is taken when start is high and busy is low. Its single result
// appears on out_result for exactly one cycle with out_valid and cannot be
// held off. Work runs through one shared serial multiply/divide unit:
// - alloc and stats run a 32-step multiply;
// - free runs a 48-step divide;
// - reset runs the divide, then the multiply for the span check, then links
//   each block into the link memory; a region rejected after the span check
//   ends after the multiply;
// - requests rejected on a quick check (empty list, address out of range,
//   zero configuration) return a result without using the unit.
// busy stays high until the result is out, so the next request can be taken
// at the same edge as the result. LINE_BYTES must be a power of two.
`include "fixed_block_free_list_allocator_defines.svh"
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int MAX_BLOCKS = 1024,
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int HW = $clog2(MAX_BLOCKS + 1);
  localparam int LB = $clog2(LINE_BYTES);
  localparam logic [HW-1:0] NULL_MARK = HW'(MAX_BLOCKS);

  logic [47:0] base_r;
  logic [31:0] rbytes_r, ibytes_r;
  logic [HW-1:0] head_r, head_nxt, total_r, total_nxt;
  logic [32:0] stride_r, stride_nxt;
  logic [47:0] span_r, span_nxt;
  logic [31:0] live_r, live_nxt, frees_r, frees_nxt;
  fsm_state_t  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [32:0] rl_stride_r, rl_stride_nxt;
  logic [HW-1:0] rl_cnt_r, rl_cnt_nxt, link_i_r, link_i_nxt;

  logic [HW-1:0] link_mem [MAX_BLOCKS];
  logic [HW-1:0] rd_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [HW-1:0] mem_wd;

  unit_req_t   ureq;
  unit_rsp_t   ursp;
  logic [47:0] uopa, quot;
  logic [32:0] uopb, rem;
  logic [64:0] prod;

  logic        accept, alloc_empty, free_oor, cfg_zero, span_bad;
  logic [47:0] off;
  logic [32:0] stride_sum, stride_calc;
  logic [65:0] span_end;

  fbfl_seq_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ureq),
    .opa  (uopa),
    .opb  (uopb),
    .rsp  (ursp),
    .quot (quot),
    .rem  (rem),
    .prod (prod)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  assign off         = in_item.release_addr - base_r;
  assign free_oor    = (in_item.release_addr < base_r) || (off >= span_r);
  assign alloc_empty = (head_r >= total_r);
  assign cfg_zero    = (base_r == 48'd0) || (rbytes_r == 32'd0) || (ibytes_r == 32'd0);
  assign stride_sum  = {1'b0, ibytes_r} + 33'(LINE_BYTES - 1);
  assign stride_calc = {stride_sum[32:LB], LB'(0)};
  assign span_end    = {1'b0, prod} + {18'b0, base_r};
  assign span_bad    = (rl_cnt_r == '0) || (span_end > 66'h1_0000_0000_0000);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.req_type)
            REQ_ALLOC: state_nxt = alloc_empty ? S_IDLE : S_ALLOC;
            REQ_FREE:  state_nxt = free_oor ? S_IDLE : S_FREE;
            REQ_RESET: state_nxt = cfg_zero ? S_IDLE : S_DIV_CNT;
            default:   state_nxt = S_STATS;
          endcase
        end
      end
      S_ALLOC, S_FREE, S_STATS: if (ursp.done) state_nxt = S_IDLE;
      S_DIV_CNT:  if (ursp.done) state_nxt = S_MUL_SPAN;
      S_MUL_SPAN: if (ursp.done) state_nxt = span_bad ? S_IDLE : S_LINK;
      S_LINK:     if (link_i_r == rl_cnt_r - HW'(1)) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_nxt      = head_r;
    total_nxt     = total_r;
    stride_nxt    = stride_r;
    span_nxt      = span_r;
    live_nxt      = live_r;
    frees_nxt     = frees_r;
    rl_stride_nxt = rl_stride_r;
    rl_cnt_nxt    = rl_cnt_r;
    link_i_nxt    = link_i_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ureq.start    = 1'b0;
    ureq.op       = OP_MUL;
    uopa          = 48'd0;
    uopb          = stride_r;
    mem_we        = 1'b0;
    mem_wa        = head_r[IW-1:0];
    mem_wd        = head_r;
    mem_re        = 1'b0;
    mem_ra        = head_r[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.req_type)
            REQ_ALLOC: begin
              if (alloc_empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_EMPTY;
              end else begin
                ureq.start = 1'b1;
                uopa       = {{(48-HW){1'b0}}, head_r};
                mem_re     = 1'b1;
              end
            end
            REQ_FREE: begin
              if (free_oor) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_RANGE;
              end else begin
                ureq.start = 1'b1;
                ureq.op    = OP_DIV;
                uopa       = off;
              end
            end
            REQ_RESET: begin
              if (cfg_zero) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_BAD_CONFIG;
                head_nxt   = NULL_MARK;
                total_nxt  = '0;
                stride_nxt = '0;
                span_nxt   = '0;
                live_nxt   = '0;
                frees_nxt  = '0;
              end else begin
                ureq.start    = 1'b1;
                ureq.op       = OP_DIV;
                uopa          = {16'b0, rbytes_r};
                uopb          = stride_calc;
                rl_stride_nxt = stride_calc;
              end
            end
            default: begin
              ureq.start = 1'b1;
              uopa       = {16'b0, live_r};
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (ursp.done) begin
          out_valid_nxt      = 1'b1;
          out_nxt.block_addr = base_r + prod[47:0];
          head_nxt  = rd_r;
          live_nxt  = (live_r != 32'hFFFF_FFFF) ? live_r + 32'd1 : live_r;
          frees_nxt = (frees_r != 32'd0) ? frees_r - 32'd1 : frees_r;
        end
      end
      S_FREE: begin
        if (ursp.done) begin
          out_valid_nxt = 1'b1;
          if (rem != 33'd0) begin
            out_nxt.status = ST_MISALIGNED;
          end else begin
            mem_we    = 1'b1;
            mem_wa    = quot[IW-1:0];
            mem_wd    = head_r;
            head_nxt  = quot[HW-1:0];
            frees_nxt = (frees_r != 32'hFFFF_FFFF) ? frees_r + 32'd1 : frees_r;
            live_nxt  = (live_r != 32'd0) ? live_r - 32'd1 : live_r;
          end
        end
      end
      S_DIV_CNT: begin
        if (ursp.done) begin
          rl_cnt_nxt = (quot > 48'(MAX_BLOCKS)) ? HW'(MAX_BLOCKS) : quot[HW-1:0];
          ureq.start = 1'b1;
          uopa       = (quot > 48'(MAX_BLOCKS)) ? 48'(MAX_BLOCKS) : {{(48-HW){1'b0}},
                       quot[HW-1:0]};
          uopb       = rl_stride_r;
        end
      end
      S_MUL_SPAN: begin
        if (ursp.done) begin
          // A bad region leaves the allocator empty; a good one is linked next.
          if (span_bad) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_BAD_CONFIG;
            head_nxt   = NULL_MARK;
            total_nxt  = '0;
            stride_nxt = '0;
            span_nxt   = '0;
            live_nxt   = '0;
            frees_nxt  = '0;
          end else begin
            span_nxt   = prod[47:0];
            stride_nxt = rl_stride_r;
            link_i_nxt = '0;
          end
        end
      end
      S_LINK: begin
        mem_we     = 1'b1;
        mem_wa     = link_i_r[IW-1:0];
        mem_wd     = (link_i_r == '0) ? NULL_MARK : link_i_r - HW'(1);
        link_i_nxt = link_i_r + HW'(1);
        if (link_i_r == rl_cnt_r - HW'(1)) begin
          out_valid_nxt = 1'b1;
          head_nxt  = link_i_r;
          total_nxt = rl_cnt_r;
          live_nxt  = '0;
          frees_nxt = {{(32-HW){1'b0}}, rl_cnt_r};
        end
      end
      S_STATS: begin
        if (ursp.done) begin
          out_valid_nxt            = 1'b1;
          out_nxt.bytes_in_use     = (prod[64:48] != 17'd0) ? MASK48 : prod[47:0];
          out_nxt.bytes_total      = span_r;
          out_nxt.live_allocations = live_r;
          out_nxt.free_tally       = frees_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      rbytes_r    <= '0;
      ibytes_r    <= '0;
      head_r      <= NULL_MARK;
      total_r     <= '0;
      stride_r    <= '0;
      span_r      <= '0;
      live_r      <= '0;
      frees_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      stride_r    <= stride_nxt;
      span_r      <= span_nxt;
      live_r      <= live_nxt;
      frees_r     <= frees_nxt;
      if (psel && penable && pwrite) begin
        case (paddr[4:3])
          REG_REGION_BASE:  base_r   <= pwdata[47:0];
          REG_REGION_BYTES: rbytes_r <= pwdata[31:0];
          REG_ITEM_BYTES:   ibytes_r <= pwdata[31:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    rl_stride_r <= rl_stride_nxt;
    rl_cnt_r    <= rl_cnt_nxt;
    link_i_r    <= link_i_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= link_mem[mem_ra];
  end

  always_comb begin
    case (paddr[4:3])
      REG_REGION_BASE:  prdata = {16'b0, base_r};
      REG_REGION_BYTES: prdata = {32'b0, rbytes_r};
      REG_ITEM_BYTES:   prdata = {32'b0, ibytes_r};
      default:          prdata = 64'd0;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  `FBFL_ASSERT_IMPL(a_result_not_busy, clk, rst_n, out_valid, !busy, "result while busy")
  `FBFL_ASSERT_IMPL(a_result_has_cause, clk, rst_n, out_valid, $past(busy || start), "result without a request")
  `FBFL_ASSERT_ALWAYS(a_head_valid, clk, rst_n, (head_r == NULL_MARK) || (head_r < total_r), "list head out of range")

endmodule

[rtl/fbfl_seq_unit.sv]
// Shared bit-serial multiplier and restoring divider.
module fbfl_seq_unit import fbfl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  unit_req_t   req,
  input  logic [47:0] opa,
  input  logic [32:0] opb,
  output unit_rsp_t   rsp,
  output logic [47:0] quot,
  output logic [32:0] rem,
  output logic [64:0] prod
);

  logic        run_r, done_r;
  unit_op_t    op_r;
  logic [32:0] b_r;
  logic [47:0] q_r, q_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic [5:0]  cnt_r;

  logic [33:0] rem_sh;
  logic [66:0] x, y, s;
  logic        cin, neg;

  // One adder serves both operations: add for multiply, subtract for divide.
  always_comb begin
    rem_sh = {acc_r[32:0], q_r[47]};
    if (op_r == OP_MUL) begin
      x   = {acc_r, 1'b0};
      y   = q_r[47] ? {34'b0, b_r} : 67'b0;
      cin = 1'b0;
    end else begin
      x   = {33'b0, rem_sh};
      y   = ~{34'b0, b_r};
      cin = 1'b1;
    end
    s   = x + y + {66'b0, cin};
    neg = s[66];
    if (op_r == OP_MUL) begin
      acc_nxt = s[65:0];
      q_nxt   = {q_r[46:0], 1'b0};
    end else begin
      acc_nxt = neg ? {32'b0, rem_sh} : {32'b0, s[33:0]};
      q_nxt   = {q_r[46:0], ~neg};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 6'd0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      b_r   <= opb;
      acc_r <= '0;
      q_r   <= (req.op == OP_MUL) ? {opa[31:0], 16'b0} : opa;
      cnt_r <= (req.op == OP_MUL) ? 6'd31 : 6'd47;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign rsp.done = done_r;
  assign quot     = q_r;
  assign rem      = acc_r[32:0];
  assign prod     = acc_r[64:0];

endmodule
